>>> rtl/core/ordered_array_edit_engine_core_macros.svh
// ----------------------------------------------------------------------------
// Ordered array edit engine - assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_EDIT_ENGINE_CORE_MACROS_SVH
`define ORDERED_ARRAY_EDIT_ENGINE_CORE_MACROS_SVH

// same-cycle implication, gated by reset
`define OAEE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("oaee assertion failed");

// next-cycle implication, gated by reset
`define OAEE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("oaee assertion failed");

// next-cycle implication, not gated by reset
`define OAEE_ASSERT_RAW(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("oaee assertion failed");

`endif

>>> rtl/core/oaee_pkg.sv
// ----------------------------------------------------------------------------
// oaee_pkg
// Types and constants of the ordered array edit engine.
// ----------------------------------------------------------------------------
package oaee_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 32;

    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

    localparam t_cnt CAP_CNT = t_cnt'(CAPACITY);

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DELETE  = 2'd1,
        REQ_READ    = 2'd2,
        REQ_REVERSE = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_NO_KEY  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type   req_type;
        logic [4:0]  position;
        t_data       insert_value;
        t_data       delete_key;
    } t_req;

    typedef struct packed {
        t_status     status;
        t_data       read_value;
        logic [4:0]  entry_count;
    } t_res;

    typedef struct packed {
        logic load;
        logic exec;
        logic rev_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_rev;
        logic rev_last;
    } t_dp_status;

endpackage

>>> rtl/core/ordered_array_edit_engine_core.sv
// ----------------------------------------------------------------------------
// ordered_array_edit_engine_core
// Ordered list of up to 16 signed entries with insert, delete, read, reverse.
// ----------------------------------------------------------------------------
// Request channel: drive i_req and raise start; the transaction is taken at a
// rising edge with start high and busy low. busy rises the cycle after.
// Result channel: o_res is valid for exactly one cycle while o_done is high;
// the receiver cannot stall it and must take it in that cycle.
// Insert, delete, read and reverse of fewer than two entries or of a full
// list go from the execute step straight to the strobe. Reverse of a partial
// list of n entries mirrors the cells in the execute step, then shifts them
// down one place per step until the entries are realigned.
// A new request is accepted in the cycle its predecessor's result is shown;
// none is taken while busy is high.
// Delete compares every occupied cell against the key in parallel.
// Reset (synchronous, active low) empties the list and clears busy and
// o_done; entry contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_array_edit_engine_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  oaee_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_done,
    output oaee_pkg::t_res  o_res
);

    oaee_pkg::t_ctrl_cmd  cmd;
    oaee_pkg::t_dp_status dp_status;

    oaee_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    oaee_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_status (dp_status),
        .o_res    (o_res)
    );

endmodule

>>> rtl/core/oaee_ctrl.sv
// ----------------------------------------------------------------------------
// oaee_ctrl
// Sequencer: accepts a transaction, runs the datapath, issues the result strobe.
// ----------------------------------------------------------------------------
module oaee_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  oaee_pkg::t_dp_status  i_status,
    output oaee_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REV
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_start;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.rev_step = (r_state == S_REV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (i_status.need_rev) begin
                        r_state <= S_REV;
                    end else begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                    end
                end
                S_REV: begin
                    if (i_status.rev_last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

>>> rtl/core/oaee_datapath.sv
// ----------------------------------------------------------------------------
// oaee_datapath
// Row of entry cells with neighbor shifts, key match, mirror and result register.
// ----------------------------------------------------------------------------
module oaee_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  oaee_pkg::t_req        i_req,
    input  oaee_pkg::t_ctrl_cmd   i_cmd,
    output oaee_pkg::t_dp_status  o_status,
    output oaee_pkg::t_res        o_res
);

    oaee_pkg::t_data r_entries [oaee_pkg::CAPACITY];
    oaee_pkg::t_data n_entries [oaee_pkg::CAPACITY];
    oaee_pkg::t_cnt  r_count;
    oaee_pkg::t_cnt  n_count;
    oaee_pkg::t_cnt  r_shift_cnt;
    oaee_pkg::t_cnt  n_shift_cnt;
    oaee_pkg::t_req  r_req;
    oaee_pkg::t_res  r_res;
    oaee_pkg::t_res  n_res;

    logic [oaee_pkg::CAPACITY-1:0] match;
    logic [oaee_pkg::CAPACITY-1:0] at_hit;
    logic                          seen;
    logic                          is_rev_long;

    always_comb begin
        seen = 1'b0;
        for (int i = 0; i < oaee_pkg::CAPACITY; i++) begin
            match[i]  = (r_entries[i] == r_req.delete_key) && (i < int'(r_count));
            seen      = seen | match[i];
            at_hit[i] = seen;
        end
    end

    assign is_rev_long = (r_req.req_type == oaee_pkg::REQ_REVERSE)
                      && (r_count >= oaee_pkg::t_cnt'(2));

    always_comb begin
        n_entries          = r_entries;
        n_count            = r_count;
        n_shift_cnt        = r_shift_cnt;
        n_res              = r_res;
        n_res.status       = oaee_pkg::ST_OK;
        n_res.read_value   = '0;

        if (i_cmd.exec) begin
            case (r_req.req_type)
                oaee_pkg::REQ_INSERT: begin
                    if (oaee_pkg::t_cnt'(r_req.position) > r_count) begin
                        n_res.status = oaee_pkg::ST_BAD_POS;
                    end else if (r_count == oaee_pkg::CAP_CNT) begin
                        n_res.status = oaee_pkg::ST_FULL;
                    end else begin
                        for (int i = 1; i < oaee_pkg::CAPACITY; i++) begin
                            if (i > int'(r_req.position)) begin
                                n_entries[i] = r_entries[i-1];
                            end
                        end
                        for (int i = 0; i < oaee_pkg::CAPACITY; i++) begin
                            if (i == int'(r_req.position)) begin
                                n_entries[i] = r_req.insert_value;
                            end
                        end
                        n_count = r_count + oaee_pkg::t_cnt'(1);
                    end
                end
                oaee_pkg::REQ_DELETE: begin
                    if (!seen) begin
                        n_res.status = oaee_pkg::ST_NO_KEY;
                    end else begin
                        for (int i = 0; i < oaee_pkg::CAPACITY - 1; i++) begin
                            if (at_hit[i]) begin
                                n_entries[i] = r_entries[i+1];
                            end
                        end
                        n_count = r_count - oaee_pkg::t_cnt'(1);
                    end
                end
                oaee_pkg::REQ_READ: begin
                    if (oaee_pkg::t_cnt'(r_req.position) >= r_count) begin
                        n_res.status = oaee_pkg::ST_BAD_POS;
                    end else begin
                        n_res.read_value = r_entries[r_req.position[oaee_pkg::IDX_W-1:0]];
                    end
                end
                default: begin
                    if (is_rev_long) begin
                        for (int i = 0; i < oaee_pkg::CAPACITY; i++) begin
                            n_entries[i] = r_entries[oaee_pkg::CAPACITY-1-i];
                        end
                        n_shift_cnt = oaee_pkg::CAP_CNT - r_count;
                    end
                end
            endcase
            n_res.entry_count = n_count;
        end

        if (i_cmd.rev_step) begin
            for (int i = 0; i < oaee_pkg::CAPACITY - 1; i++) begin
                n_entries[i] = r_entries[i+1];
            end
            n_shift_cnt = r_shift_cnt - oaee_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_shift_cnt <= '0;
        end else begin
            r_count     <= n_count;
            r_shift_cnt <= n_shift_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_status.need_rev = is_rev_long && (r_count != oaee_pkg::CAP_CNT);
    assign o_status.rev_last = (r_shift_cnt == oaee_pkg::t_cnt'(1));
    assign o_res             = r_res;

endmodule

>>> rtl/core/oaee_checker.sv
// ----------------------------------------------------------------------------
// oaee_checker
// Port-level assertions for the ordered array edit engine, bound to the top.
// ----------------------------------------------------------------------------
`include "ordered_array_edit_engine_core_macros.svh"

module oaee_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            o_done,
    input  oaee_pkg::t_res  o_res
);

    `OAEE_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `OAEE_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `OAEE_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, o_done, o_res.entry_count <= 5'(oaee_pkg::CAPACITY))
    `OAEE_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && (o_res.status != oaee_pkg::ST_OK), o_res.read_value == '0)
    `OAEE_ASSERT_RAW(a_reset_quiet, i_clk, !i_rst_n, !busy && !o_done)

endmodule

bind ordered_array_edit_engine_core oaee_checker u_oaee_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

>>> tb/ordered_array_edit_engine_core_tb.sv
// ----------------------------------------------------------------------------
// ordered_array_edit_engine_core_tb
// Self-checking bench for the ordered array edit engine. A local model of the
// list predicts the status, read value and count of every accepted request.
// Each strobed result is checked against the oldest prediction. Directed
// edge cases come first, then random edit streams with and without gaps.
// ----------------------------------------------------------------------------
module ordered_array_edit_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start   = 1'b0;
    oaee_pkg::t_req  i_req   = '0;
    logic            busy;
    logic            o_done;
    oaee_pkg::t_res  o_res;

    oaee_pkg::t_data list_q [oaee_pkg::CAPACITY];
    int              list_len = 0;
    oaee_pkg::t_res  pending_results [$];
    int              n_err = 0;
    int              idle_pct = 0;

    ordered_array_edit_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic oaee_pkg::t_res apply_edit(oaee_pkg::t_req r);
        oaee_pkg::t_res  res;
        int              hit;
        oaee_pkg::t_data tmp;
        res.status     = oaee_pkg::ST_OK;
        res.read_value = '0;
        hit            = -1;
        case (r.req_type)
            oaee_pkg::REQ_INSERT: begin
                if (int'(r.position) > list_len) begin
                    res.status = oaee_pkg::ST_BAD_POS;
                end else if (list_len >= oaee_pkg::CAPACITY) begin
                    res.status = oaee_pkg::ST_FULL;
                end else begin
                    for (int i = list_len; i > int'(r.position); i--)
                        list_q[i] = list_q[i-1];
                    list_q[r.position[oaee_pkg::IDX_W-1:0]] = r.insert_value;
                    list_len++;
                end
            end
            oaee_pkg::REQ_DELETE: begin
                for (int i = 0; i < list_len; i++)
                    if (hit < 0 && list_q[i] == r.delete_key)
                        hit = i;
                if (hit < 0) begin
                    res.status = oaee_pkg::ST_NO_KEY;
                end else begin
                    for (int i = hit; i + 1 < list_len; i++)
                        list_q[i] = list_q[i+1];
                    list_len--;
                end
            end
            oaee_pkg::REQ_READ: begin
                if (int'(r.position) >= list_len)
                    res.status = oaee_pkg::ST_BAD_POS;
                else
                    res.read_value = list_q[r.position[oaee_pkg::IDX_W-1:0]];
            end
            default: begin
                for (int i = 0; i < list_len / 2; i++) begin
                    tmp                     = list_q[i];
                    list_q[i]               = list_q[list_len-1-i];
                    list_q[list_len-1-i]    = tmp;
                end
            end
        endcase
        res.entry_count = list_len[4:0];
        return res;
    endfunction

    task automatic send_req(input oaee_pkg::t_req req);
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_results.push_back(apply_edit(req));
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic send_op(input oaee_pkg::t_req_type kind, input int pos,
                           input oaee_pkg::t_data val, input oaee_pkg::t_data key);
        oaee_pkg::t_req r;
        r.req_type     = kind;
        r.position     = pos[4:0];
        r.insert_value = val;
        r.delete_key   = key;
        send_req(r);
    endtask

    function automatic oaee_pkg::t_data rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3, 4: return oaee_pkg::t_data'($urandom_range(0, 7)) - 4;
            default: return oaee_pkg::t_data'($urandom);
        endcase
    endfunction

    function automatic oaee_pkg::t_req random_req();
        oaee_pkg::t_req r;
        int             pick;
        int             ins_w;
        int             del_w;
        int             rd_w;
        if (list_len < 4) begin
            ins_w = 55; del_w = 20; rd_w = 15;
        end else if (list_len > 13) begin
            ins_w = 30; del_w = 40; rd_w = 20;
        end else begin
            ins_w = 40; del_w = 25; rd_w = 25;
        end
        pick = $urandom_range(0, 99);
        if (pick < ins_w)
            r.req_type = oaee_pkg::REQ_INSERT;
        else if (pick < ins_w + del_w)
            r.req_type = oaee_pkg::REQ_DELETE;
        else if (pick < ins_w + del_w + rd_w)
            r.req_type = oaee_pkg::REQ_READ;
        else
            r.req_type = oaee_pkg::REQ_REVERSE;
        r.insert_value = rand_value();
        r.delete_key   = rand_value();
        if (list_len > 0 && $urandom_range(0, 99) < 70)
            r.delete_key = list_q[$urandom_range(0, list_len - 1)];
        if ($urandom_range(0, 9) == 0)
            r.position = 5'($urandom_range(0, 16));
        else if (r.req_type == oaee_pkg::REQ_READ && list_len > 0)
            r.position = 5'($urandom_range(0, list_len - 1));
        else
            r.position = 5'($urandom_range(0, list_len));
        return r;
    endfunction

    task automatic run_random(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_req(random_req());
    endtask

    task automatic test_edge_cases();
        idle_pct = 0;
        send_op(oaee_pkg::REQ_READ,    0,  32'sd0,  32'sd0);
        send_op(oaee_pkg::REQ_REVERSE, 0,  32'sd0,  32'sd0);
        send_op(oaee_pkg::REQ_DELETE,  0,  32'sd0,  32'sd5);
        send_op(oaee_pkg::REQ_INSERT,  1,  32'sd1,  32'sd0);
        send_op(oaee_pkg::REQ_INSERT,  0,  32'sh7fff_ffff, 32'sh8000_0000);
        send_op(oaee_pkg::REQ_REVERSE, 0,  32'sd0,  32'sd0);
        send_op(oaee_pkg::REQ_INSERT,  1,  32'sh8000_0000, 32'sh7fff_ffff);
        send_op(oaee_pkg::REQ_INSERT,  0,  -32'sd1, 32'sd0);
        send_op(oaee_pkg::REQ_INSERT,  16, 32'sd9,  32'sd0);
        send_op(oaee_pkg::REQ_READ,    2,  32'sd0,  32'sd0);
        send_op(oaee_pkg::REQ_READ,    3,  32'sd0,  32'sd0);
        for (int i = 0; i < 13; i++)
            send_op(oaee_pkg::REQ_INSERT, (i % 2) ? list_len : 0,
                    oaee_pkg::t_data'(i % 3), -32'sd1);
        send_op(oaee_pkg::REQ_INSERT,  16, 32'sd7,  32'sd0);
        send_op(oaee_pkg::REQ_INSERT,  0,  32'sd7,  32'sd0);
        send_op(oaee_pkg::REQ_REVERSE, 0,  32'sd0,  32'sd0);
        send_op(oaee_pkg::REQ_READ,    15, 32'sd0,  32'sd0);
        send_op(oaee_pkg::REQ_READ,    16, 32'sd0,  32'sd0);
        send_op(oaee_pkg::REQ_DELETE,  0,  32'sd0,  32'sd1);
        send_op(oaee_pkg::REQ_DELETE,  0,  32'sd0,  32'sh8000_0000);
        send_op(oaee_pkg::REQ_DELETE,  0,  32'sd0,  32'sd1234);
        send_op(oaee_pkg::REQ_REVERSE, 0,  32'sd0,  32'sd0);
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        run_random(500);
    endtask

    task automatic test_sender_gaps();
        idle_pct = 58;
        run_random(450);
    endtask

    task automatic test_light_gaps();
        idle_pct = 12;
        run_random(400);
    endtask

    task automatic test_burst_tail();
        idle_pct = 0;
        run_random(350);
    endtask

    always @(posedge i_clk) begin
        oaee_pkg::t_res exp_res;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transaction: status %0d read_value %0d entry_count %0d",
                       o_res.status, o_res.read_value, o_res.entry_count);
                n_err++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_res.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_res.status);
                    n_err++;
                end
                if (o_res.read_value !== exp_res.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           exp_res.read_value, o_res.read_value);
                    n_err++;
                end
                if (o_res.entry_count !== exp_res.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_res.entry_count, o_res.entry_count);
                    n_err++;
                end
            end
        end
    end

    initial begin
        int guard;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_edge_cases();
        test_back_to_back();
        test_sender_gaps();
        test_light_gaps();
        test_burst_tail();
        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d transactions never returned", pending_results.size());
            n_err++;
        end
        if (n_err == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/oaee_pkg.sv
rtl/core/oaee_ctrl.sv
rtl/core/oaee_datapath.sv
rtl/core/ordered_array_edit_engine_core.sv
rtl/core/oaee_checker.sv
tb/ordered_array_edit_engine_core_tb.sv
